@@ design/sliding_window_rms_activity_gate_core_macros.svh @@
// ----------------------------------------------------------------------------
// Sliding window RMS gate - assertion macros
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RMS_ACTIVITY_GATE_CORE_MACROS_SVH
`define SLIDING_WINDOW_RMS_ACTIVITY_GATE_CORE_MACROS_SVH

// same-cycle implication
`define SWRAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swrag assertion failed");

// next-cycle implication
`define SWRAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swrag assertion failed");

`endif

@@ design/swrag_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window RMS gate - package
// Shared widths, defaults, register map and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package swrag_pkg;

  localparam int WINDOW_DEF = 64;
  localparam int HOP_DEF    = 32;

  localparam int SAMPLE_W = 13;
  localparam int RMS_W    = 16;
  localparam int THR_W    = 16;

  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  // register index is paddr[CFG_AW-1]
  localparam logic REG_IDX_THRESHOLD = 1'b0;

  localparam logic [THR_W-1:0] THR_RESET = 16'd288;
  localparam logic [RMS_W-1:0] RMS_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_PROD,
    ST_DIFF,
    ST_ROOT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ design/swrag_in_if.sv @@
// ----------------------------------------------------------------------------
// Sliding window RMS gate - sample channel
// Valid/ready channel carrying one ADC sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface swrag_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [swrag_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ design/swrag_out_if.sv @@
// ----------------------------------------------------------------------------
// Sliding window RMS gate - result channel
// Valid/ready channel carrying the RMS value and the activity flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface swrag_out_if;
  logic                          valid;
  logic                          ready;
  logic [swrag_pkg::RMS_W-1:0]   rms_q4;
  logic                          active;

  modport source (output valid, output rms_q4, output active, input ready);
  modport sink   (input valid, input rms_q4, input active, output ready);
endinterface

`default_nettype wire

@@ design/sliding_window_rms_activity_gate_core.sv @@
// ----------------------------------------------------------------------------
// Sliding window RMS activity gate with mean removal
// Item without result: window read on accept, then write-back of sums (IDLE, UPD).
// Item with result: IDLE, UPD, PROD, DIFF, then the bit-serial square root in ROOT,
//   a reciprocal divide in DIV if WINDOW is no power of 2, and OUT.
// A held result stalls the next one.
// Reset clears pointer, counts and sums and loads the default threshold; the window memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rms_activity_gate_core #(
  parameter int WINDOW = swrag_pkg::WINDOW_DEF,
  parameter int HOP    = swrag_pkg::HOP_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  swrag_in_if.sink                         in_chan,
  swrag_out_if.source                      out_chan,
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire [swrag_pkg::CFG_AW-1:0]      cfg_paddr,
  input  wire [swrag_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [swrag_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                             cfg_pready
);

  localparam int SAMPLE_W = swrag_pkg::SAMPLE_W;
  localparam int RMS_W    = swrag_pkg::RMS_W;
  localparam int THR_W    = swrag_pkg::THR_W;
  localparam int LOGW     = $clog2(WINDOW);
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int HOP_W    = $clog2(HOP + 1);
  localparam int SUM_W    = LOGW + 14;
  localparam int SQ_W     = LOGW + 25;
  localparam int D_W      = 2 * LOGW + 25;
  localparam int N_STEPS  = (D_W + 8 + 1) / 2;
  localparam int RAD_W    = 2 * N_STEPS;
  localparam int ROOT_W   = N_STEPS;
  localparam int REM_W    = ROOT_W + 2;
  localparam int CNT_W    = $clog2(N_STEPS);
  localparam int SSQ_W    = 2 * SAMPLE_W;
  localparam bit POW2     = ((1 << LOGW) == WINDOW);
  localparam int RECIP_W  = ROOT_W + 1;
  localparam int RECIP_SH = ROOT_W + LOGW;
  localparam int PROD_W   = ROOT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  swrag_pkg::state_t state_r, state_nxt;

  // control state
  logic [LOGW-1:0]          wp_r;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic [HOP_W-1:0]         hop_r, hop_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]          sumsq_r, sumsq_nxt;
  logic [THR_W-1:0]         thr_r;
  logic                     out_valid_r;

  // datapath
  logic [SAMPLE_W-1:0]      sample_r;
  logic [SAMPLE_W-1:0]      old_r;
  logic [D_W-1:0]           wsq_r, sq_r;
  logic [RAD_W-1:0]         rad_r;
  logic [REM_W-1:0]         rem_r, rem_sh, rem_nxt, trial;
  logic [ROOT_W-1:0]        root_r, root_nxt;
  logic [ROOT_W-1:0]        quo_r;
  logic [PROD_W-1:0]        div_prod;
  logic [CNT_W-1:0]         cnt_r;
  logic [RMS_W-1:0]         out_rms_r, rms_sat;
  logic                     out_active_r;

  logic [SAMPLE_W-1:0]      win_mem [WINDOW];

  logic                     in_rdy, mem_rd, mem_wr, out_load;
  logic                     full, emit, root_ge, cnt_last, accept, cfg_wr;
  logic signed [SAMPLE_W-1:0] smp_s, old_s;
  logic signed [SSQ_W-1:0]  smp_sq, old_sq;
  logic signed [2*SUM_W-1:0] sum_sq;
  logic [FILL_W-1:0]        fill_inc;
  logic [HOP_W-1:0]         hop_inc;

  assign accept   = in_chan.valid && in_rdy;
  assign cnt_last = (cnt_r == CNT_W'(N_STEPS - 1));

  // window update arithmetic
  always_comb begin
    full     = (fill_r == FILL_W'(WINDOW));
    smp_s    = $signed(sample_r);
    old_s    = full ? $signed(old_r) : '0;
    smp_sq   = smp_s * smp_s;
    old_sq   = old_s * old_s;
    sum_nxt  = sum_r + SUM_W'(smp_s) - SUM_W'(old_s);
    sumsq_nxt = sumsq_r + SQ_W'($unsigned(smp_sq)) - SQ_W'($unsigned(old_sq));
    fill_inc = fill_r + FILL_W'(1);
    hop_inc  = hop_r + HOP_W'(1);
    if (!full) begin
      fill_nxt = fill_inc;
      emit     = (fill_inc == FILL_W'(WINDOW));
      hop_nxt  = '0;
    end else begin
      fill_nxt = fill_r;
      emit     = (hop_inc >= HOP_W'(HOP));
      hop_nxt  = emit ? '0 : hop_inc;
    end
  end

  // square root steps and reciprocal divide
  always_comb begin
    sum_sq   = sum_r * sum_r;
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    root_ge  = (rem_sh >= trial);
    rem_nxt  = root_ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[ROOT_W-2:0], root_ge};
    div_prod = PROD_W'(quo_r) * PROD_W'(RECIP);
    rms_sat  = (|quo_r[ROOT_W-1:RMS_W]) ? swrag_pkg::RMS_MAX : quo_r[RMS_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swrag_pkg::ST_IDLE: if (accept) state_nxt = swrag_pkg::ST_UPD;
      swrag_pkg::ST_UPD:  state_nxt = emit ? swrag_pkg::ST_PROD : swrag_pkg::ST_IDLE;
      swrag_pkg::ST_PROD: state_nxt = swrag_pkg::ST_DIFF;
      swrag_pkg::ST_DIFF: state_nxt = swrag_pkg::ST_ROOT;
      swrag_pkg::ST_ROOT: begin
        if (cnt_last) state_nxt = POW2 ? swrag_pkg::ST_OUT : swrag_pkg::ST_DIV;
      end
      swrag_pkg::ST_DIV:  state_nxt = swrag_pkg::ST_OUT;
      swrag_pkg::ST_OUT:  if (out_load) state_nxt = swrag_pkg::ST_IDLE;
      default:            state_nxt = swrag_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_rdy   = 1'b0;
    mem_rd   = 1'b0;
    mem_wr   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      swrag_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        mem_rd = in_chan.valid;
      end
      swrag_pkg::ST_UPD: mem_wr = 1'b1;
      swrag_pkg::ST_OUT: out_load = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  // window memory: read old entry on accept, write new sample next cycle
  always_ff @(posedge clk) begin
    if (mem_wr) win_mem[wp_r] <= sample_r;
    if (mem_rd) old_r <= win_mem[wp_r];
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[swrag_pkg::CFG_AW-1] == swrag_pkg::REG_IDX_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swrag_pkg::ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      hop_r       <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      thr_r       <= swrag_pkg::THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_wr) begin
        wp_r    <= (wp_r == LOGW'(WINDOW - 1)) ? '0 : wp_r + LOGW'(1);
        fill_r  <= fill_nxt;
        hop_r   <= hop_nxt;
        sum_r   <= sum_nxt;
        sumsq_r <= sumsq_nxt;
      end
      if (cfg_wr) thr_r <= cfg_pwdata[THR_W-1:0];
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      swrag_pkg::ST_IDLE: if (accept) sample_r <= in_chan.sample;
      swrag_pkg::ST_PROD: begin
        wsq_r <= D_W'(sumsq_r) * D_W'(WINDOW);
        sq_r  <= D_W'($unsigned(sum_sq));
      end
      swrag_pkg::ST_DIFF: begin
        rad_r  <= RAD_W'({wsq_r - sq_r, 8'b0});
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      swrag_pkg::ST_ROOT: begin
        rad_r  <= rad_r << 2;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_last ? '0 : cnt_r + CNT_W'(1);
        if (cnt_last) begin
          quo_r <= POW2 ? (root_nxt >> LOGW) : root_nxt;
        end
      end
      swrag_pkg::ST_DIV: begin
        quo_r <= ROOT_W'(div_prod >> RECIP_SH);
      end
      swrag_pkg::ST_OUT: begin
        if (out_load) begin
          out_rms_r    <= rms_sat;
          out_active_r <= (rms_sat >= thr_r);
        end
      end
      default: ;
    endcase
  end

  assign in_chan.ready   = in_rdy;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.rms_q4 = out_rms_r;
  assign out_chan.active = out_active_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[swrag_pkg::CFG_AW-1] == swrag_pkg::REG_IDX_THRESHOLD) ?
                      swrag_pkg::CFG_DW'(thr_r) : '0;

endmodule

`default_nettype wire

@@ design/swrag_checker.sv @@
// ----------------------------------------------------------------------------
// Sliding window RMS gate - port checker
// Watches the top-level ports; bound to the core below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_rms_activity_gate_core_macros.svh"

module swrag_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_valid,
  input wire                           in_ready,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [swrag_pkg::RMS_W-1:0]    out_rms_q4,
  input wire                           out_active,
  input wire                           cfg_psel,
  input wire                           cfg_penable,
  input wire                           cfg_pwrite,
  input wire                           cfg_pready,
  input wire [swrag_pkg::CFG_AW-1:0]   cfg_paddr,
  input wire [swrag_pkg::CFG_DW-1:0]   cfg_pwdata
);

  logic [swrag_pkg::THR_W-1:0] thr_q_r;

  // shadow of the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_q_r <= swrag_pkg::THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[swrag_pkg::CFG_AW-1] == swrag_pkg::REG_IDX_THRESHOLD)) begin
      thr_q_r <= cfg_pwdata[swrag_pkg::THR_W-1:0];
    end
  end

  `SWRAG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SWRAG_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `SWRAG_ASSERT_NOW(a_no_instant_result, clk, rst_n, $rose(out_valid), !$past(in_valid && in_ready))
  `SWRAG_ASSERT_NOW(a_active_flag, clk, rst_n, out_valid, out_active == (out_rms_q4 >= thr_q_r))

endmodule

bind sliding_window_rms_activity_gate_core swrag_checker u_swrag_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_rms_q4  (out_chan.rms_q4),
  .out_active  (out_chan.active),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_pready  (cfg_pready),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata)
);

`default_nettype wire
